// ----- hw/rtl/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants of the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int SHP_MAX_COLS     = 2048;
   localparam int SHP_MAX_ROWS     = 4096;
   localparam int SHP_MIN_SIZE     = 3;
   localparam int SHP_CHAN_W       = 8;
   localparam int SHP_PIX_W        = 3 * SHP_CHAN_W;
   localparam int SHP_WIDTH_REG_W  = 12;
   localparam int SHP_HEIGHT_REG_W = 13;
   localparam int SHP_CSR_INDEX_W  = 2;
   localparam int SHP_CSR_DATA_W   = 13;

   localparam logic [11:0] SHP_WIDTH_RESET  = 12'd640;
   localparam logic [12:0] SHP_HEIGHT_RESET = 13'd480;

   typedef enum logic [SHP_CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BORDER_MODE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one window column: current row, row above, two rows above
   typedef struct packed {
      pixel_type below;
      pixel_type mid;
      pixel_type top;
   } column_type;

   typedef struct packed {
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic       drain;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_end;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/sharpen_3x3_convolution_top.sv -----
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution_top
// Streaming 3x3 sharpen filter for RGB frames in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock once the window is
// filled, while rsp_stall does not hold back the output. The result for a pixel
// leaves frame_width+1 transfers after the pixel arrives, so frame_width+1
// drain transfers flush the end of a frame. Inside the block a transfer passes
// the registered read of the two line buffers, then the kernel into the output
// register. Frame border pixels come out as zero, or as the source pixel when
// border_mode is set. Line buffers need no clearing after reset.
// ----------------------------------------------------------------------------
module sharpen_3x3_convolution_top
   import shp_pkg::*;
#(
   parameter int MAX_COLS = SHP_MAX_COLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  req_payload_type             req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  logic                        csr_write,
   input  logic [SHP_CSR_INDEX_W-1:0]  csr_index,
   input  logic [SHP_CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int WW = CW + 1;

   logic [11:0]     width_ff, width_in;
   logic [12:0]     height_ff, height_in;
   logic            border_ff, border_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [12:0]     row_ff, row_in;

   logic            s1_valid_ff, s1_valid_in;
   logic            s1_emit_ff, s1_emit_in;
   logic            s1_last_ff, s1_last_in;
   logic            s1_edge_ff, s1_edge_in;
   logic [CW-1:0]   s1_col_ff, s1_col_in;
   pixel_type       s1_cur_ff, s1_cur_in;
   logic            byp_ff, byp_in;
   pixel_type       byp_cur_ff, byp_cur_in;
   pixel_type       byp_mid_ff, byp_mid_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [WW-1:0]   w_eff;
   logic [12:0]     h_eff;
   logic            accept;
   logic            s1_adv;
   logic            emit0, last0, edge0, col_wrap;
   logic [12:0]     orow;
   pixel_type       cur0;
   pixel_type       rd_above, rd_two;
   pixel_type       mid_eff, top_eff;
   column_type      new_col, win0, win1;
   pixel_type       sharp;
   logic            size_write;

   // effective frame size
   always_comb begin
      if (32'(width_ff) < SHP_MIN_SIZE) begin
         w_eff = WW'(SHP_MIN_SIZE);
      end else if (32'(width_ff) > MAX_COLS) begin
         w_eff = WW'(MAX_COLS);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (32'(height_ff) < SHP_MIN_SIZE) begin
         h_eff = 13'(SHP_MIN_SIZE);
      end else if (32'(height_ff) > SHP_MAX_ROWS) begin
         h_eff = 13'(SHP_MAX_ROWS);
      end else begin
         h_eff = height_ff;
      end
   end

   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   // position decode of the incoming transfer
   always_comb begin
      emit0    = (row_ff >= 13'd2) || ((row_ff == 13'd1) && (col_ff != '0));
      orow     = (col_ff == '0) ? row_ff - 13'd2 : row_ff - 13'd1;
      last0    = (col_ff == '0) && (orow == h_eff - 13'd1);
      edge0    = (col_ff == '0) || (col_ff == CW'(1)) || (orow == 13'd0)
                 || (orow == h_eff - 13'd1);
      col_wrap = (WW'({1'b0, col_ff}) + WW'(1)) >= w_eff;
      cur0     = req_payload.drain ? '0
                 : {req_payload.pix_red, req_payload.pix_green, req_payload.pix_blue};
   end

   // configuration and position
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      border_in  = border_ff;
      size_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_in   = csr_wdata[SHP_WIDTH_REG_W-1:0];
               size_write = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in  = csr_wdata[SHP_HEIGHT_REG_W-1:0];
               size_write = 1'b1;
            end
            CSR_BORDER_MODE: begin
               border_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (emit0 && last0) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            if (row_ff != 13'h1FFF) begin
               row_in = row_ff + 13'd1;
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // read stage, with bypass when the next transfer reads the column just written
   always_comb begin
      mid_eff = byp_ff ? byp_cur_ff : rd_above;
      top_eff = byp_ff ? byp_mid_ff : rd_two;

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      s1_emit_in = s1_emit_ff;
      s1_last_in = s1_last_ff;
      s1_edge_in = s1_edge_ff;
      s1_col_in  = s1_col_ff;
      s1_cur_in  = s1_cur_ff;
      byp_in     = byp_ff;
      byp_cur_in = byp_cur_ff;
      byp_mid_in = byp_mid_ff;
      if (accept) begin
         s1_emit_in = emit0;
         s1_last_in = last0;
         s1_edge_in = edge0;
         s1_col_in  = col_ff;
         s1_cur_in  = cur0;
         byp_in     = s1_adv && (s1_col_ff == col_ff);
         byp_cur_in = s1_cur_ff;
         byp_mid_in = mid_eff;
      end
   end

   shp_line_buffer #(
      .DEPTH (MAX_COLS),
      .AW    (CW)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_cur_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_above)
   );

   shp_line_buffer #(
      .DEPTH (MAX_COLS),
      .AW    (CW)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_eff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_two)
   );

   // window: newest column, then the one before it
   assign new_col = '{below: s1_cur_ff, mid: mid_eff, top: top_eff};

   shp_column_cell u_cell_0 (
      .clock    (clock),
      .shift_en (s1_adv),
      .nbr_col  (new_col),
      .col_out  (win0)
   );

   shp_column_cell u_cell_1 (
      .clock    (clock),
      .shift_en (s1_adv),
      .nbr_col  (win0),
      .col_out  (win1)
   );

   shp_kernel u_kernel_red (
      .centre (win0.mid.red),
      .top    (win0.top.red),
      .below  (win0.below.red),
      .left   (win1.mid.red),
      .right  (mid_eff.red),
      .result (sharp.red)
   );

   shp_kernel u_kernel_green (
      .centre (win0.mid.green),
      .top    (win0.top.green),
      .below  (win0.below.green),
      .left   (win1.mid.green),
      .right  (mid_eff.green),
      .result (sharp.green)
   );

   shp_kernel u_kernel_blue (
      .centre (win0.mid.blue),
      .top    (win0.top.blue),
      .below  (win0.below.blue),
      .left   (win1.mid.blue),
      .right  (mid_eff.blue),
      .result (sharp.blue)
   );

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
         if (s1_edge_ff) begin
            if (border_ff) begin
               rsp_payload_in.out_red   = win0.mid.red;
               rsp_payload_in.out_green = win0.mid.green;
               rsp_payload_in.out_blue  = win0.mid.blue;
            end else begin
               rsp_payload_in.out_red   = 8'd0;
               rsp_payload_in.out_green = 8'd0;
               rsp_payload_in.out_blue  = 8'd0;
            end
         end else begin
            rsp_payload_in.out_red   = sharp.red;
            rsp_payload_in.out_green = sharp.green;
            rsp_payload_in.out_blue  = sharp.blue;
         end
         rsp_payload_in.frame_end = s1_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SHP_WIDTH_RESET;
         height_ff    <= SHP_HEIGHT_RESET;
         border_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         border_ff    <= border_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff     <= s1_emit_in;
      s1_last_ff     <= s1_last_in;
      s1_edge_ff     <= s1_edge_in;
      s1_col_ff      <= s1_col_in;
      s1_cur_ff      <= s1_cur_in;
      byp_cur_ff     <= byp_cur_in;
      byp_mid_ff     <= byp_mid_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- hw/rtl/shp_line_buffer.sv -----
// ----------------------------------------------------------------------------
// shp_line_buffer
// One line of pixels; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module shp_line_buffer
   import shp_pkg::*;
#(
   parameter int DEPTH = SHP_MAX_COLS,
   parameter int AW    = $clog2(SHP_MAX_COLS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pixel_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pixel_type     rd_data
);

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/shp_column_cell.sv -----
// ----------------------------------------------------------------------------
// shp_column_cell
// One column of the 3x3 window; takes its neighbor's column on each shift.
// ----------------------------------------------------------------------------
module shp_column_cell
   import shp_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  column_type nbr_col,
   output column_type col_out
);

   column_type col_ff;
   column_type col_in;

   always_comb begin
      col_in = col_ff;
      if (shift_en) begin
         col_in = nbr_col;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col_out = col_ff;

endmodule

// ----- hw/rtl/shp_kernel.sv -----
// ----------------------------------------------------------------------------
// shp_kernel
// Sharpen one channel: 5*centre minus four neighbors, clamped to 0..255.
// ----------------------------------------------------------------------------
module shp_kernel
   import shp_pkg::*;
(
   input  logic [7:0] centre,
   input  logic [7:0] top,
   input  logic [7:0] below,
   input  logic [7:0] left,
   input  logic [7:0] right,
   output logic [7:0] result
);

   logic        [10:0] centre5;
   logic signed [11:0] sum;

   always_comb begin
      centre5 = {1'b0, centre, 2'b00} + {3'b000, centre};
      sum = $signed({1'b0, centre5})
          - $signed({4'b0000, top})
          - $signed({4'b0000, below})
          - $signed({4'b0000, left})
          - $signed({4'b0000, right});
      if (sum < 0) begin
         result = 8'd0;
      end else if (sum > 12'sd255) begin
         result = 8'd255;
      end else begin
         result = sum[7:0];
      end
   end

endmodule
